### rtl/pthp_pkg.sv
package pthp_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_UPDATED   = 2'd0,
    STATUS_NO_STAMPS = 2'd1,
    STATUS_CORRUPT   = 2'd2
  } status_e;

  localparam int unsigned StampW = 33;
  localparam int unsigned RawW   = 40;
  localparam int unsigned HlenW  = 9;

  // Reset value of the max_delta register, in 90 kHz ticks
  localparam logic [StampW-1:0] MAX_DELTA_RESET = 33'd180000;

  // One finished header as handed from the front end to the back end
  typedef struct packed {
    status_e             status;
    logic                two_stamps;
    logic                buf_err;
    logic [HlenW-1:0]    hlen;
    logic [RawW-1:0]     raw_pts;
    logic [RawW-1:0]     raw_dts;
  } evt_t;

endpackage

### rtl/pes_timestamp_header_parser_top.sv
// Channel   Handshake              Payload
// input     in_valid_i/in_stall_o  data_byte_i, first_i, avail_len_i, buffer_errors_i
// output    out_valid_o/out_stall_i status_o, pts_o, pts_valid_o, dts_o, dts_valid_o,
//                                  header_length_o
// config    cfg_we_i               cfg_data_i (max_delta)
//
// One header word is accepted per cycle while the result queue is not full. A
// result passes from the front parser into the queue, then through the back
// decoder into the output register.
// Reset clears parse state; the parser ignores words until one with first set.
// in_stall_o rises only while the result queue is full; out_stall_i holds the
// output register and backs up the queue.
module pes_timestamp_header_parser_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [pthp_pkg::StampW-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  data_byte_i,
  input  logic                        first_i,
  input  logic [15:0]                 avail_len_i,
  input  logic                        buffer_errors_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [pthp_pkg::StampW-1:0] pts_o,
  output logic                        pts_valid_o,
  output logic [pthp_pkg::StampW-1:0] dts_o,
  output logic                        dts_valid_o,
  output logic [pthp_pkg::HlenW-1:0]  header_length_o
);
  import pthp_pkg::*;

  logic accept;
  logic push, full, head_valid, pop;
  evt_t push_evt, head_evt;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !in_stall_o;

  pthp_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .data_byte_i     (data_byte_i),
    .first_i         (first_i),
    .avail_len_i     (avail_len_i),
    .buffer_errors_i (buffer_errors_i),
    .push_o          (push),
    .evt_o           (push_evt)
  );

  pthp_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .evt_i   (push_evt),
    .full_o  (full),
    .valid_o (head_valid),
    .evt_o   (head_evt),
    .pop_i   (pop)
  );

  pthp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .head_valid_i    (head_valid),
    .head_i          (head_evt),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .pts_o           (pts_o),
    .pts_valid_o     (pts_valid_o),
    .dts_o           (dts_o),
    .dts_valid_o     (dts_valid_o),
    .header_length_o (header_length_o)
  );

endmodule

### rtl/pthp_front.sv
module pthp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         data_byte_i,
  input  logic               first_i,
  input  logic [15:0]        avail_len_i,
  input  logic               buffer_errors_i,
  output logic               push_o,
  output pthp_pkg::evt_t     evt_o
);
  import pthp_pkg::*;

  localparam logic [3:0] POS_PREFIX      = 4'd0;
  localparam logic [3:0] POS_FLAGS       = 4'd1;
  localparam logic [3:0] POS_LENGTH      = 4'd2;
  localparam logic [3:0] POS_STAMP_FIRST = 4'd3;
  localparam logic [3:0] POS_PTS_LAST    = 4'd7;
  localparam logic [3:0] POS_DTS_LAST    = 4'd12;

  localparam logic [1:0] PREFIX_OK     = 2'b10;
  localparam logic [1:0] FLAGS_PTS     = 2'b10;
  localparam logic [1:0] FLAGS_PTS_DTS = 2'b11;

  localparam logic [7:0]  MIN_LEN_PTS     = 8'd5;
  localparam logic [7:0]  MIN_LEN_PTS_DTS = 8'd10;
  localparam logic [15:0] MIN_AVAIL       = 16'd3;
  localparam logic [HlenW-1:0] HLEN_FIXED = 9'd3;

  logic [3:0]      pos_q, pos_d;
  logic            fin_q, fin_d;
  logic [7:0]      prefix_q, prefix_d;
  logic [7:0]      flags_q, flags_d;
  logic [7:0]      len_q, len_d;
  logic [15:0]     avail_q, avail_d;
  logic            err_q, err_d;
  logic [RawW-1:0] raw1_q, raw1_d;
  logic [RawW-1:0] raw2_q, raw2_d;

  // Walk the header one word at a time and classify it
  always_comb begin
    pos_d    = pos_q;
    fin_d    = fin_q;
    prefix_d = prefix_q;
    flags_d  = flags_q;
    len_d    = len_q;
    avail_d  = avail_q;
    err_d    = err_q;
    raw1_d   = raw1_q;
    raw2_d   = raw2_q;
    push_o   = 1'b0;
    evt_o    = '0;
    evt_o.status = STATUS_CORRUPT;

    if (accept_i) begin
      // restart the parse on a header start
      if (first_i) begin
        pos_d   = POS_PREFIX;
        fin_d   = 1'b0;
        avail_d = avail_len_i;
        err_d   = buffer_errors_i;
      end

      if (first_i && (avail_len_i < MIN_AVAIL)) begin
        push_o = 1'b1;
        fin_d  = 1'b1;
      end else if (!fin_d) begin
        case (pos_d)
          POS_PREFIX: begin
            prefix_d = data_byte_i;
            pos_d    = POS_FLAGS;
          end
          POS_FLAGS: begin
            flags_d = data_byte_i;
            pos_d   = POS_LENGTH;
          end
          POS_LENGTH: begin
            len_d = data_byte_i;
            if (((avail_d - MIN_AVAIL) < {8'd0, data_byte_i}) ||
                (prefix_d[7:6] != PREFIX_OK)) begin
              push_o = 1'b1;
              fin_d  = 1'b1;
            end else begin
              case (flags_d[7:6])
                FLAGS_PTS_DTS: begin
                  if (data_byte_i < MIN_LEN_PTS_DTS) begin
                    push_o = 1'b1;
                    fin_d  = 1'b1;
                  end else begin
                    pos_d = POS_STAMP_FIRST;
                  end
                end
                FLAGS_PTS: begin
                  if (data_byte_i < MIN_LEN_PTS) begin
                    push_o = 1'b1;
                    fin_d  = 1'b1;
                  end else begin
                    pos_d = POS_STAMP_FIRST;
                  end
                end
                default: begin
                  // no timestamps in this header
                  push_o       = 1'b1;
                  fin_d        = 1'b1;
                  evt_o.status = STATUS_NO_STAMPS;
                  evt_o.hlen   = {1'b0, data_byte_i} + HLEN_FIXED;
                end
              endcase
            end
          end
          default: begin
            // shift the stamp bytes in
            if (pos_d <= POS_PTS_LAST) begin
              raw1_d = {raw1_q[RawW-9:0], data_byte_i};
            end else begin
              raw2_d = {raw2_q[RawW-9:0], data_byte_i};
            end
            evt_o.status     = STATUS_UPDATED;
            evt_o.buf_err    = err_d;
            evt_o.hlen       = {1'b0, len_d} + HLEN_FIXED;
            evt_o.raw_pts    = raw1_d;
            evt_o.raw_dts    = raw2_d;
            if ((pos_d == POS_PTS_LAST) && (flags_d[7:6] == FLAGS_PTS)) begin
              push_o           = 1'b1;
              fin_d            = 1'b1;
              evt_o.two_stamps = 1'b0;
            end else if (pos_d >= POS_DTS_LAST) begin
              push_o           = 1'b1;
              fin_d            = 1'b1;
              evt_o.two_stamps = 1'b1;
            end else begin
              pos_d = pos_d + 4'd1;
            end
          end
        endcase
      end
    end
  end

  // Hold parse control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= POS_PREFIX;
      fin_q <= 1'b1;
    end else begin
      pos_q <= pos_d;
      fin_q <= fin_d;
    end
  end

  // Hold header fields and raw stamps
  always_ff @(posedge clk_i) begin
    prefix_q <= prefix_d;
    flags_q  <= flags_d;
    len_q    <= len_d;
    avail_q  <= avail_d;
    err_q    <= err_d;
    raw1_q   <= raw1_d;
    raw2_q   <= raw2_d;
  end

endmodule

### rtl/pthp_queue.sv
module pthp_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pthp_pkg::evt_t evt_i,
  output logic           full_o,
  output logic           valid_o,
  output pthp_pkg::evt_t evt_o,
  input  logic           pop_i
);
  import pthp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PTR_LAST = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CNT_FULL = CntW'(Depth);

  evt_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CNT_FULL);
  assign valid_o = (cnt_q != '0);
  assign evt_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Store pushed words
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= evt_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

### rtl/pthp_back.sv
module pthp_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pthp_pkg::StampW-1:0]    cfg_data_i,
  input  logic                           head_valid_i,
  input  pthp_pkg::evt_t                 head_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     status_o,
  output logic [pthp_pkg::StampW-1:0]    pts_o,
  output logic                           pts_valid_o,
  output logic [pthp_pkg::StampW-1:0]    dts_o,
  output logic                           dts_valid_o,
  output logic [pthp_pkg::HlenW-1:0]     header_length_o
);
  import pthp_pkg::*;

  // Check the three marker bits and gather the 33 stamp bits
  function automatic logic [StampW:0] decode_stamp(input logic [RawW-1:0] raw);
    logic ok;
    ok = raw[32] & raw[16] & raw[0];
    decode_stamp = ok ? {1'b1, raw[35:33], raw[31:17], raw[15:1]} : '0;
  endfunction

  logic [StampW-1:0] max_delta_q;
  logic              valid_q;
  logic [1:0]        status_q;
  logic [StampW-1:0] pts_q, dts_q;
  logic              pv_q, dv_q;
  logic [HlenW-1:0]  hlen_q;

  logic              load;
  logic [StampW:0]   dec_p, dec_d;
  logic [StampW-1:0] p_val, d_val, diff;
  logic              pv, dv, too_far;

  assign load  = head_valid_i && (!valid_q || !out_stall_i);
  assign pop_o = load;

  // Decode stamps and apply the delta and error checks
  always_comb begin
    dec_p   = decode_stamp(head_i.raw_pts);
    dec_d   = head_i.two_stamps ? decode_stamp(head_i.raw_dts) : dec_p;
    p_val   = dec_p[StampW-1:0];
    d_val   = dec_d[StampW-1:0];
    diff    = p_val - d_val;
    too_far = head_i.two_stamps && (diff > max_delta_q);
    pv      = dec_p[StampW];
    dv      = dec_d[StampW];
    if (too_far || head_i.buf_err || (head_i.status != STATUS_UPDATED)) begin
      pv = 1'b0;
      dv = 1'b0;
    end
  end

  // Hold the max_delta register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_delta_q <= MAX_DELTA_RESET;
    end else if (cfg_we_i) begin
      max_delta_q <= cfg_data_i;
    end
  end

  // Hold the output word until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q <= head_i.status;
      pts_q    <= pv ? p_val : '0;
      pv_q     <= pv;
      dts_q    <= dv ? d_val : '0;
      dv_q     <= dv;
      hlen_q   <= head_i.hlen;
    end
  end

  assign out_valid_o     = valid_q;
  assign status_o        = status_q;
  assign pts_o           = pts_q;
  assign pts_valid_o     = pv_q;
  assign dts_o           = dts_q;
  assign dts_valid_o     = dv_q;
  assign header_length_o = hlen_q;

endmodule

### rtl/pthp_checker.sv
module pthp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [1:0]                  status_o,
  input logic [pthp_pkg::StampW-1:0] pts_o,
  input logic                        pts_valid_o,
  input logic [pthp_pkg::StampW-1:0] dts_o,
  input logic                        dts_valid_o,
  input logic [pthp_pkg::HlenW-1:0]  header_length_o
);
  import pthp_pkg::*;

  // A stalled output word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // Corrupt headers carry no stamps and no length
  a_corrupt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_CORRUPT) |->
      !pts_valid_o && !dts_valid_o && (header_length_o == '0))
    else $error("corrupt result carries data");

  // Headers without stamps still report their length
  a_no_stamps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_NO_STAMPS) |->
      !pts_valid_o && !dts_valid_o && (header_length_o >= 9'd3))
    else $error("no-stamp result malformed");

  // Invalid stamps read as zero
  a_zero_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pts_valid_o || (pts_o == '0)) && (dts_valid_o || (dts_o == '0)))
    else $error("invalid stamp not zero");

  // A stamp header is at least eight words long
  a_stamp_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_UPDATED) |-> (header_length_o >= 9'd8))
    else $error("stamp header too short");

endmodule

bind pes_timestamp_header_parser_top pthp_checker u_pthp_checker (.*);
